[hw/rtl/chic_pkg.sv]
`default_nettype none

package chic_pkg;

  typedef enum logic [1:0] {
    ACT_CAL     = 2'd0,
    ACT_FINISH  = 2'd1,
    ACT_MEASURE = 2'd2,
    ACT_LOAD    = 2'd3
  } action_t;

  // Angle accumulator in degrees scaled by 2^ANGLE_FRAC.
  localparam int ANGLE_FRAC = 20;
  localparam int Z_W        = 31;
  // Vector datapath: 17-bit magnitude after negation, times 256, plus CORDIC gain.
  localparam int XY_W       = 28;
  localparam int TBL_LEN    = 24;
  localparam int TBL_IDX_W  = 5;

  typedef logic [TBL_IDX_W-1:0] tbl_idx_t;
  typedef logic signed [Z_W-1:0] angle_t;

  localparam logic signed [15:0] MIN_RESET = 16'sd2000;
  localparam logic signed [15:0] MAX_RESET = -16'sd2000;

  // atan(2^-i) in degrees scaled by 2^20, rounded.
  localparam angle_t ATAN_TBL [TBL_LEN] = '{
    31'sd47185920, 31'sd27855475, 31'sd14718068, 31'sd7471121,
    31'sd3750058,  31'sd1876857,  31'sd938658,   31'sd469357,
    31'sd234682,   31'sd117342,   31'sd58671,    31'sd29335,
    31'sd14668,    31'sd7334,     31'sd3667,     31'sd1833,
    31'sd917,      31'sd458,      31'sd229,      31'sd115,
    31'sd57,       31'sd29,       31'sd14,       31'sd7
  };

  localparam angle_t ANGLE_180 = 31'sd188743680;

endpackage

`default_nettype wire

[hw/rtl/compass_hard_iron_calibration_heading_top.sv]
`default_nettype none

// Hard-iron calibration and heading for a three-axis magnetometer. Each request carries an
// action code: a calibration sample widens the per-axis extremes (zero values are ignored),
// finish sets each offset to the midpoint of its axis extremes, load writes the offsets from
// the sample fields, and measure subtracts the offsets with 16-bit saturation and computes
// atan2(y, x) with a single CORDIC rotation stage reused once per iteration. A measure request
// passes through the subtract, setup, iteration, rounding and result states in that order, with
// the iteration state repeated once per CORDIC iteration; the other actions go straight to the
// result state. The block holds in_stall high while a request is in progress and until its
// result has been taken. The heading is given in units of 2^-HEADING_FRAC_BITS degree, both
// as -180..+180 and as 0..360 degrees.
module compass_hard_iron_calibration_heading_top #(
  parameter int CORDIC_ITERATIONS = 16,
  parameter int HEADING_FRAC_BITS = 6
) (
  input  wire               clk,
  input  wire               rst_n,

  input  wire               in_valid,
  output logic              in_stall,
  input  wire  [1:0]        in_action,
  input  wire  signed [15:0] in_mag_x,
  input  wire  signed [15:0] in_mag_y,
  input  wire  signed [15:0] in_mag_z,

  output logic              out_valid,
  input  wire               out_stall,
  output logic signed [15:0] out_corrected_x,
  output logic signed [15:0] out_corrected_y,
  output logic signed [15:0] out_corrected_z,
  output logic signed [14:0] out_heading_signed,
  output logic        [14:0] out_heading_unsigned,
  output logic signed [15:0] out_offset_x_out,
  output logic signed [15:0] out_offset_y_out,
  output logic signed [15:0] out_offset_z_out
);

  localparam int CNT_W    = $clog2(CORDIC_ITERATIONS);
  localparam int XY_W     = chic_pkg::XY_W;
  localparam int Z_W      = chic_pkg::Z_W;
  localparam int RND_SH   = chic_pkg::ANGLE_FRAC - HEADING_FRAC_BITS;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CORDIC_ITERATIONS - 1);
  localparam logic signed [Z_W-1:0] RND_HALF  = Z_W'(64'sd1 <<< (RND_SH - 1));
  localparam logic signed [Z_W-1:0] HEAD_LIM  = Z_W'(64'sd180 <<< HEADING_FRAC_BITS);
  localparam logic signed [Z_W-1:0] HEAD_WRAP = Z_W'(64'sd360 <<< HEADING_FRAC_BITS);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_PREP  = 6'b000010,
    S_SETUP = 6'b000100,
    S_ITER  = 6'b001000,
    S_ROUND = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  logic [1:0]               act_r;
  logic signed [15:0]       mag_r [3];
  logic signed [15:0]       min_r [3];
  logic signed [15:0]       max_r [3];
  logic signed [15:0]       off_r [3];
  logic signed [15:0]       corr_r [3];
  logic signed [XY_W-1:0]   x_r, y_r;
  logic signed [Z_W-1:0]    z_r;
  logic                     zero_vec_r;
  logic [CNT_W-1:0]         cnt_r;
  logic signed [14:0]       head_s_r;
  logic        [14:0]       head_u_r;

  logic                     in_acc;
  logic                     out_acc;
  logic signed [16:0]       diff [3];
  logic signed [15:0]       sat [3];
  logic signed [XY_W-1:0]   cx, cy, sx, sy, dx, dy;
  logic signed [Z_W-1:0]    rnd, lim_s, hu_full;
  logic signed [16:0]       mid_sum [3];

  assign in_acc   = in_valid && !in_stall;
  assign out_acc  = out_valid && !out_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

  function automatic logic signed [15:0] mag_in(input int k);
    logic signed [15:0] v;
    case (k)
      0:       v = in_mag_x;
      1:       v = in_mag_y;
      default: v = in_mag_z;
    endcase
    return v;
  endfunction

  // Saturating subtract of the offsets.
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      diff[k] = 17'(mag_r[k]) - 17'(off_r[k]);
      if (diff[k] > 17'sd32767) begin
        sat[k] = 16'sh7fff;
      end else if (diff[k] < -17'sd32768) begin
        sat[k] = -16'sh8000;
      end else begin
        sat[k] = diff[k][15:0];
      end
      mid_sum[k] = 17'(max_r[k]) + 17'(min_r[k]);
    end
  end

  // CORDIC setup: move the vector into the right half plane.
  always_comb begin
    cx = XY_W'(corr_r[0]);
    cy = XY_W'(corr_r[1]);
    if (corr_r[0] < 0) begin
      sx = -cx;
      sy = -cy;
    end else begin
      sx = cx;
      sy = cy;
    end
  end

  // One rotation stage, shared by all iterations.
  assign dx = y_r >>> cnt_r;
  assign dy = x_r >>> cnt_r;

  always_comb begin
    rnd = (z_r + RND_HALF) >>> RND_SH;
    if (rnd > HEAD_LIM) begin
      lim_s = HEAD_LIM;
    end else if (rnd < -HEAD_LIM) begin
      lim_s = -HEAD_LIM;
    end else begin
      lim_s = rnd;
    end
    if (zero_vec_r) begin
      lim_s = '0;
    end
    hu_full = (lim_s < 0) ? lim_s + HEAD_WRAP : lim_s;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = (chic_pkg::action_t'(in_action) == chic_pkg::ACT_MEASURE) ?
                      S_PREP : S_DONE;
        end
      end
      S_PREP:  state_nxt = S_SETUP;
      S_SETUP: state_nxt = S_ITER;
      S_ITER: begin
        if (cnt_r == CNT_LAST) begin
          state_nxt = S_ROUND;
        end
      end
      S_ROUND: state_nxt = S_DONE;
      S_DONE: begin
        if (out_acc) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      for (int k = 0; k < 3; k++) begin
        min_r[k] <= chic_pkg::MIN_RESET;
        max_r[k] <= chic_pkg::MAX_RESET;
        off_r[k] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (in_acc) begin
        unique case (chic_pkg::action_t'(in_action))
          chic_pkg::ACT_CAL: begin
            for (int k = 0; k < 3; k++) begin
              if (mag_in(k) != 16'sd0) begin
                if (mag_in(k) < min_r[k]) begin
                  min_r[k] <= mag_in(k);
                end
                if (mag_in(k) > max_r[k]) begin
                  max_r[k] <= mag_in(k);
                end
              end
            end
          end
          chic_pkg::ACT_FINISH: begin
            // Halve the sum, rounding toward zero.
            for (int k = 0; k < 3; k++) begin
              off_r[k] <= 16'((mid_sum[k] + 17'(mid_sum[k][16])) >>> 1);
            end
          end
          chic_pkg::ACT_LOAD: begin
            off_r[0] <= in_mag_x;
            off_r[1] <= in_mag_y;
            off_r[2] <= in_mag_z;
          end
          chic_pkg::ACT_MEASURE: begin
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          act_r    <= in_action;
          mag_r[0] <= in_mag_x;
          mag_r[1] <= in_mag_y;
          mag_r[2] <= in_mag_z;
          for (int k = 0; k < 3; k++) begin
            corr_r[k] <= '0;
          end
          head_s_r <= '0;
          head_u_r <= '0;
        end
      end
      S_PREP: begin
        for (int k = 0; k < 3; k++) begin
          corr_r[k] <= sat[k];
        end
      end
      S_SETUP: begin
        x_r        <= sx <<< 8;
        y_r        <= sy <<< 8;
        cnt_r      <= '0;
        zero_vec_r <= (corr_r[0] == 16'sd0) && (corr_r[1] == 16'sd0);
        if (corr_r[0] < 0) begin
          z_r <= (corr_r[1] >= 0) ? chic_pkg::ANGLE_180 : -chic_pkg::ANGLE_180;
        end else begin
          z_r <= '0;
        end
      end
      S_ITER: begin
        if (y_r >= 0) begin
          x_r <= x_r + dx;
          y_r <= y_r - dy;
          z_r <= z_r + chic_pkg::ATAN_TBL[chic_pkg::tbl_idx_t'(cnt_r)];
        end else begin
          x_r <= x_r - dx;
          y_r <= y_r + dy;
          z_r <= z_r - chic_pkg::ATAN_TBL[chic_pkg::tbl_idx_t'(cnt_r)];
        end
        cnt_r <= cnt_r + 1'b1;
      end
      S_ROUND: begin
        head_s_r <= lim_s[14:0];
        head_u_r <= hu_full[14:0];
      end
      S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  assign out_corrected_x      = corr_r[0];
  assign out_corrected_y      = corr_r[1];
  assign out_corrected_z      = corr_r[2];
  assign out_heading_signed   = head_s_r;
  assign out_heading_unsigned = head_u_r;
  assign out_offset_x_out     = off_r[0];
  assign out_offset_y_out     = off_r[1];
  assign out_offset_z_out     = off_r[2];

`ifndef SYNTHESIS
  // Only a measure request may leave corrected values or a heading behind.
  a_zero_unless_measure: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && chic_pkg::action_t'(act_r) != chic_pkg::ACT_MEASURE) |->
      (corr_r[0] == 16'sd0 && corr_r[1] == 16'sd0 && corr_r[2] == 16'sd0 &&
       head_s_r == 15'sd0 && head_u_r == 15'd0))
    else $error("nonzero measurement fields on a non-measure result");

  // One request at a time: nothing is accepted while a result is pending.
  a_no_accept_with_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !out_valid)
    else $error("request accepted while a result is pending");

  // A finish request leaves the X offset at the midpoint of the X axis extremes.
  a_finish_midpoint: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && chic_pkg::action_t'(in_action) == chic_pkg::ACT_FINISH) |=>
      (17'(off_r[0]) * 2 - (17'($past(max_r[0])) + 17'($past(min_r[0]))) == 17'sd0 ||
       17'(off_r[0]) * 2 - (17'($past(max_r[0])) + 17'($past(min_r[0]))) == 17'sd1 ||
       17'(off_r[0]) * 2 - (17'($past(max_r[0])) + 17'($past(min_r[0]))) == -17'sd1))
    else $error("finish produced a wrong X offset");

  // The iteration loop leaves after exactly the configured number of steps.
  a_iter_exit: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ITER && cnt_r == CNT_LAST) |=> (state_r == S_ROUND))
    else $error("CORDIC loop did not end on its last iteration");
`endif

endmodule

`default_nettype wire
